// ===== rtl/sqvg_pkg.sv =====
package sqvg_pkg;

  localparam int COORD_BITS = 16;
  localparam int UV_FRAC_BITS = 16;
  localparam int ANGLE_BITS = 16;

  localparam int QBITS = ANGLE_BITS - 2;
  localparam int T_LSH = (QBITS <= 16) ? 16 - QBITS : 0;
  localparam int T_RSH = (QBITS > 16) ? QBITS - 16 : 0;
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << QBITS;

  localparam logic [16:0] T_ONE = 17'd65536;
  localparam logic [16:0] POLY_A = 17'd102873;
  localparam logic [15:0] POLY_B = 16'd41906;
  localparam logic [12:0] POLY_C = 13'd4569;

  localparam int DIV_STAGES = 6;
  localparam int DIV_SPS = (UV_FRAC_BITS + DIV_STAGES - 1) / DIV_STAGES;

  localparam int SUM_W = 42;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_BL = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_TR = 2'd3
  } corner_e;

  typedef struct packed {
    logic [15:0]        tex_id;
    logic signed [15:0] depth;
    logic [31:0]        color;
    corner_e            corner;
    logic               last;
  } meta_t;

  typedef struct packed {
    logic signed [17:0] rx;
    logic signed [17:0] ry;
    logic signed [16:0] px;
    logic signed [16:0] py;
  } geo_t;

  typedef struct packed {
    meta_t                  meta;
    geo_t                   geo;
    logic [16:0]            edge_u;
    logic [15:0]            size_u;
    logic [16:0]            edge_v;
    logic [15:0]            size_v;
    logic [ANGLE_BITS-1:0]  ang_s;
    logic [ANGLE_BITS-1:0]  ang_c;
  } vert_t;

  typedef struct packed {
    logic [15:0]           r;
    logic [UV_FRAC_BITS:0] q;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s, logic [15:0] size);
    logic [16:0] r2;
    div_st_t     n;
    r2 = {s.r, 1'b0};
    if (r2 >= {1'b0, size}) begin
      n.r = 16'(r2 - {1'b0, size});
      n.q = {s.q[UV_FRAC_BITS-1:0], 1'b1};
    end else begin
      n.r = r2[15:0];
      n.q = {s.q[UV_FRAC_BITS-1:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== rtl/sprite_quad_vertex_generator.sv =====
// channel  direction  words                        handshake
// in       input      one sprite request           in_valid_i / in_ready_o
// out      output     one vertex, four per sprite  out_valid_o / out_ready_i
//
// one vertex enters the pipe per cycle unless the output stalls, so a sprite takes four vertex slots of issue
// a request goes through the input registers and the issue stage, then the six stages, to its first vertex
// the six stages are set by the restoring uv divider, and by the sine polynomial with the rotate multiply and sum
// reset clears the issue state and the valid bits only
// a stall at the output freezes the whole pipe, nothing is dropped or repeated
module sprite_quad_vertex_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [15:0]                       tex_id_i,
  input  logic [31:0]                       tex_size_i,
  input  logic [63:0]                       dest_rect_i,
  input  logic [63:0]                       src_rect_i,
  input  logic [15:0]                       angle_i,
  input  logic [31:0]                       pivot_offset_i,
  input  logic [31:0]                       color_abgr_i,
  input  logic signed [15:0]                layer_depth_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [15:0]                       out_tex_id_o,
  output logic signed [sqvg_pkg::COORD_BITS-1:0] vert_x_o,
  output logic signed [sqvg_pkg::COORD_BITS-1:0] vert_y_o,
  output logic signed [15:0]                vert_depth_o,
  output logic [sqvg_pkg::UV_FRAC_BITS:0]   tex_u_o,
  output logic [sqvg_pkg::UV_FRAC_BITS:0]   tex_v_o,
  output logic [31:0]                       vert_color_o,
  output logic [1:0]                        corner_o,
  output logic                              last_vertex_o
);

  localparam int SW = sqvg_pkg::SUM_W;
  localparam logic signed [SW-1:0] C_HI = SW'((64'sd1 <<< (sqvg_pkg::COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] C_LO = -C_HI - SW'(1);

  logic                en;
  logic                v0;
  sqvg_pkg::vert_t     vert0;
  logic [6:1]          v_q;
  sqvg_pkg::meta_t     meta_q [1:6];
  sqvg_pkg::geo_t      geo_q [1:4];
  logic signed [18:0]  sn, cs;

  logic signed [36:0]  xa_q, xb_q, ya_q, yb_q;
  logic signed [16:0]  px5_q, py5_q;
  logic signed [SW-1:0] xs, ys, qx, qy;
  logic signed [sqvg_pkg::COORD_BITS-1:0] x_q, y_q;

  assign en = !v_q[6] || out_ready_i;

  sqvg_issue u_issue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tex_id_i       (tex_id_i),
    .tex_size_i     (tex_size_i),
    .dest_rect_i    (dest_rect_i),
    .src_rect_i     (src_rect_i),
    .angle_i        (angle_i),
    .pivot_offset_i (pivot_offset_i),
    .color_abgr_i   (color_abgr_i),
    .layer_depth_i  (layer_depth_i),
    .en_i           (en),
    .vert_valid_o   (v0),
    .vert_o         (vert0)
  );

  sqvg_sine u_sin (.clk_i(clk_i), .en_i(en), .ang_i(vert0.ang_s), .sin_o(sn));
  sqvg_sine u_cos (.clk_i(clk_i), .en_i(en), .ang_i(vert0.ang_c), .sin_o(cs));

  sqvg_uvdiv u_udiv (
    .clk_i(clk_i), .en_i(en), .edge_i(vert0.edge_u), .size_i(vert0.size_u), .q_o(tex_u_o)
  );
  sqvg_uvdiv u_vdiv (
    .clk_i(clk_i), .en_i(en), .edge_i(vert0.edge_v), .size_i(vert0.size_v), .q_o(tex_v_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:1], v0};
    end
  end

  always_comb begin
    xs = (SW'(px5_q) <<< 16) + SW'(xa_q) + SW'(xb_q);
    ys = (SW'(py5_q) <<< 16) - SW'(ya_q) + SW'(yb_q);
    // truncate toward zero
    qx = xs >>> 16;
    if (xs[SW-1] && (xs[15:0] != 16'd0)) qx = qx + SW'(1);
    qy = ys >>> 16;
    if (ys[SW-1] && (ys[15:0] != 16'd0)) qy = qy + SW'(1);
    if (qx > C_HI) qx = C_HI;
    else if (qx < C_LO) qx = C_LO;
    if (qy > C_HI) qy = C_HI;
    else if (qy < C_LO) qy = C_LO;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[1] <= vert0.meta;
      geo_q[1]  <= vert0.geo;
      for (int k = 2; k <= 6; k++) meta_q[k] <= meta_q[k-1];
      for (int k = 2; k <= 4; k++) geo_q[k] <= geo_q[k-1];
      xa_q  <= signed'(geo_q[4].rx) * cs;
      xb_q  <= signed'(geo_q[4].ry) * sn;
      ya_q  <= signed'(geo_q[4].rx) * sn;
      yb_q  <= signed'(geo_q[4].ry) * cs;
      px5_q <= geo_q[4].px;
      py5_q <= geo_q[4].py;
      x_q   <= sqvg_pkg::COORD_BITS'(qx);
      y_q   <= sqvg_pkg::COORD_BITS'(qy);
    end
  end

  assign out_valid_o   = v_q[6];
  assign out_tex_id_o  = meta_q[6].tex_id;
  assign vert_x_o      = x_q;
  assign vert_y_o      = y_q;
  assign vert_depth_o  = meta_q[6].depth;
  assign vert_color_o  = meta_q[6].color;
  assign corner_o      = meta_q[6].corner;
  assign last_vertex_o = meta_q[6].last;

endmodule

// ===== rtl/sqvg_issue.sv =====
module sqvg_issue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          tex_id_i,
  input  logic [31:0]          tex_size_i,
  input  logic [63:0]          dest_rect_i,
  input  logic [63:0]          src_rect_i,
  input  logic [15:0]          angle_i,
  input  logic [31:0]          pivot_offset_i,
  input  logic [31:0]          color_abgr_i,
  input  logic signed [15:0]   layer_depth_i,
  input  logic                 en_i,
  output logic                 vert_valid_o,
  output sqvg_pkg::vert_t      vert_o
);

  logic        busy_q, busy_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;

  logic [15:0]        tex_id_q;
  logic [31:0]        tex_size_q;
  logic [63:0]        dest_q;
  logic [63:0]        src_q;
  logic [15:0]        angle_q;
  logic [31:0]        pivot_q;
  logic [31:0]        color_q;
  logic signed [15:0] depth_q;

  logic                  vv_q;
  sqvg_pkg::vert_t       vert_q, vert_d;

  logic [15:0] tw, th, sx, sy, sw, sh, dw, dh, dx, dy, ox, oy;
  logic        right, bottom;

  assign in_ready_o = !busy_q || (en_i && cnt_q == sqvg_pkg::CORNER_TR);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q && en_i) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == sqvg_pkg::CORNER_TR) busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = sqvg_pkg::CORNER_TL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
      vv_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (en_i) vv_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tex_id_q   <= tex_id_i;
      tex_size_q <= tex_size_i;
      dest_q     <= dest_rect_i;
      src_q      <= src_rect_i;
      angle_q    <= angle_i;
      pivot_q    <= pivot_offset_i;
      color_q    <= color_abgr_i;
      depth_q    <= layer_depth_i;
    end
    if (en_i) vert_q <= vert_d;
  end

  always_comb begin
    tw = (tex_size_q[31:16] == 16'd0) ? 16'd1 : tex_size_q[31:16];
    th = (tex_size_q[15:0] == 16'd0) ? 16'd1 : tex_size_q[15:0];
    sx = src_q[63:48];
    sy = src_q[47:32];
    sw = src_q[31:16];
    sh = src_q[15:0];
    // whole texture
    if (src_q == 64'd0) begin
      sw = tw;
      sh = th;
    end
    dx = dest_q[63:48];
    dy = dest_q[47:32];
    dw = dest_q[31:16];
    dh = dest_q[15:0];
    ox = pivot_q[31:16];
    oy = pivot_q[15:0];
    right  = (cnt_q == sqvg_pkg::CORNER_BR) || (cnt_q == sqvg_pkg::CORNER_TR);
    bottom = (cnt_q == sqvg_pkg::CORNER_BL) || (cnt_q == sqvg_pkg::CORNER_BR);

    vert_d.meta.tex_id = tex_id_q;
    vert_d.meta.depth  = depth_q;
    vert_d.meta.color  = color_q;
    vert_d.meta.corner = sqvg_pkg::corner_e'(cnt_q);
    vert_d.meta.last   = (cnt_q == sqvg_pkg::CORNER_TR);

    vert_d.geo.rx = (right ? {2'b00, dw} : 18'd0) - {{2{ox[15]}}, ox};
    vert_d.geo.ry = (bottom ? {2'b00, dh} : 18'd0) - {{2{oy[15]}}, oy};
    vert_d.geo.px = {dx[15], dx} + {ox[15], ox};
    vert_d.geo.py = {dy[15], dy} + {oy[15], oy};

    vert_d.edge_u = right ? ({1'b0, sx} + {1'b0, sw}) : {1'b0, sx};
    vert_d.size_u = tw;
    vert_d.edge_v = bottom ? ({1'b0, sy} + {1'b0, sh}) : {1'b0, sy};
    vert_d.size_v = th;

    vert_d.ang_s = sqvg_pkg::ANGLE_BITS'(angle_q);
    vert_d.ang_c = sqvg_pkg::ANGLE_BITS'(angle_q) + sqvg_pkg::QUARTER_TURN;
  end

  assign vert_valid_o = vv_q;
  assign vert_o       = vert_q;

endmodule

// ===== rtl/sqvg_sine.sv =====
module sqvg_sine (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [sqvg_pkg::ANGLE_BITS-1:0] ang_i,
  output logic signed [18:0]              sin_o
);

  logic [1:0]                    quad;
  logic [sqvg_pkg::QBITS-1:0]    r;
  logic [39:0]                   tw;
  logic [16:0]                   t;
  logic [33:0]                   tt;
  logic [29:0]                   m1;
  logic [32:0]                   m2;
  logic [33:0]                   m3;

  logic [16:0] t1_q, t2_q, t3_q;
  logic        n1_q, n2_q, n3_q;
  logic [16:0] sq1_q, sq2_q;
  logic [15:0] p2_q;
  logic [16:0] p3_q;
  logic signed [18:0] s_q;

  always_comb begin
    quad = ang_i[sqvg_pkg::ANGLE_BITS-1 -: 2];
    r    = ang_i[sqvg_pkg::QBITS-1:0];
    tw   = (40'(r) << sqvg_pkg::T_LSH) >> sqvg_pkg::T_RSH;
    t    = quad[0] ? (sqvg_pkg::T_ONE - tw[16:0]) : tw[16:0];
    tt   = 34'(t) * 34'(t);
    m1   = 30'(sq1_q) * 30'(sqvg_pkg::POLY_C);
    m2   = 33'(sq2_q) * 33'(p2_q);
    m3   = 34'(t3_q) * 34'(p3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t;
      n1_q  <= quad[1];
      sq1_q <= tt[32:16];

      t2_q  <= t1_q;
      n2_q  <= n1_q;
      sq2_q <= sq1_q;
      p2_q  <= sqvg_pkg::POLY_B - m1[29:16];

      t3_q  <= t2_q;
      n3_q  <= n2_q;
      p3_q  <= sqvg_pkg::POLY_A - m2[32:16];

      s_q   <= n3_q ? -$signed({1'b0, m3[33:16]}) : $signed({1'b0, m3[33:16]});
    end
  end

  assign sin_o = s_q;

endmodule

// ===== rtl/sqvg_uvdiv.sv =====
module sqvg_uvdiv (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [16:0]                     edge_i,
  input  logic [15:0]                     size_i,
  output logic [sqvg_pkg::UV_FRAC_BITS:0] q_o
);

  sqvg_pkg::div_st_t st_q [sqvg_pkg::DIV_STAGES-1];
  logic [15:0]       size_q [sqvg_pkg::DIV_STAGES-1];
  logic              ovf_q [sqvg_pkg::DIV_STAGES-1];
  logic [sqvg_pkg::UV_FRAC_BITS:0] out_q;

  for (genvar k = 0; k < sqvg_pkg::DIV_STAGES; k++) begin : g_stage
    sqvg_pkg::div_st_t st0;
    sqvg_pkg::div_st_t st;
    logic [15:0]       size;
    logic              ovf;

    if (k == 0) begin : g_first
      logic b;

      always_comb begin
        size   = size_i;
        // quotient would need more than the integer bit
        ovf    = {1'b0, edge_i} >= {1'b0, size_i, 1'b0};
        b      = edge_i >= {1'b0, size_i};
        st0.r  = b ? 16'(edge_i - {1'b0, size_i}) : edge_i[15:0];
        st0.q  = {{sqvg_pkg::UV_FRAC_BITS{1'b0}}, b};
      end
    end else begin : g_next
      always_comb begin
        size = size_q[k-1];
        ovf  = ovf_q[k-1];
        st0  = st_q[k-1];
      end
    end

    always_comb begin
      st = st0;
      for (int i = 0; i < sqvg_pkg::DIV_SPS; i++) begin
        if (k * sqvg_pkg::DIV_SPS + i < sqvg_pkg::UV_FRAC_BITS) begin
          st = sqvg_pkg::div_step(st, size);
        end
      end
    end

    if (k < sqvg_pkg::DIV_STAGES - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[k]   <= st;
          size_q[k] <= size;
          ovf_q[k]  <= ovf;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i) out_q <= ovf ? '1 : st.q;
      end
    end
  end

  assign q_o = out_q;

endmodule

// ===== rtl/sqvg_checker.sv =====
module sqvg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  corner_o,
  input logic        last_vertex_o,
  input logic signed [15:0] vert_x_o
);

  // a sprite occupies the issue stage for four vertex slots
  a_no_back_to_back_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken twice in a row");

  a_last_is_tr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_vertex_o == (corner_o == sqvg_pkg::CORNER_TR)))
    else $error("last flag does not match corner");

  a_corner_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_vertex_o) |=>
      (!out_valid_o || corner_o == $past(corner_o) + 2'd1))
    else $error("corner order broken");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(corner_o) && $stable(vert_x_o)))
    else $error("stalled word changed");

endmodule

bind sprite_quad_vertex_generator sqvg_checker u_sqvg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .corner_o      (corner_o),
  .last_vertex_o (last_vertex_o),
  .vert_x_o      (vert_x_o)
);
